/* design/rewf_pkg.sv */
`default_nettype none

package rewf_pkg;

	// fixed frame geometry
	localparam int HEADER_WINDOW           = 8;
	localparam int TRAILER_WINDOW          = 12;
	localparam int FIRST_KIND_HEADER_WORDS = 20;

	localparam int WORD_W  = 16;
	localparam int LEN_W   = 16;
	localparam int COUNT_W = 16;
	localparam int TYPE_W  = 2;

	// marker words
	localparam logic [WORD_W-1:0] MARK_8000 = 16'h8000;
	localparam logic [WORD_W-1:0] MARK_0001 = 16'h0001;
	localparam logic [WORD_W-1:0] MARK_FFFF = 16'hFFFF;

	// leading nibbles of the ranged markers
	localparam logic [3:0] NIB_9 = 4'h9;
	localparam logic [3:0] NIB_A = 4'hA;
	localparam logic [3:0] NIB_E = 4'hE;
	localparam logic [3:0] NIB_F = 4'hF;

	// packet type codes
	localparam logic [TYPE_W-1:0] TYPE_NONE   = 2'd0;
	localparam logic [TYPE_W-1:0] TYPE_FIRST  = 2'd1;
	localparam logic [TYPE_W-1:0] TYPE_SECOND = 2'd2;

	// per-word match flags computed by the front end
	typedef struct packed {
		logic is_8000;
		logic is_0001;
		logic is_ffff;
		logic nib_9;
		logic nib_a;
		logic nib_e;
		logic nib_f;
	} word_class_t;

	// one queued word with its flags
	typedef struct packed {
		logic [WORD_W-1:0] word;
		word_class_t       cls;
	} queue_item_t;

endpackage

`default_nettype wire

/* design/rewf_front.sv */
`default_nettype none

module rewf_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [15:0]           in_word,
	output logic                  q_valid,
	output rewf_pkg::queue_item_t q_item,
	input  wire                   q_pop
);
	import rewf_pkg::*;

	queue_item_t mem_q [0:1];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	queue_item_t new_item;
	logic        push;

	// classify the incoming word against every marker
	always_comb begin
		new_item.word        = in_word;
		new_item.cls.is_8000 = (in_word == MARK_8000);
		new_item.cls.is_0001 = (in_word == MARK_0001);
		new_item.cls.is_ffff = (in_word == MARK_FFFF);
		new_item.cls.nib_9   = (in_word[15:12] == NIB_9);
		new_item.cls.nib_a   = (in_word[15:12] == NIB_A);
		new_item.cls.nib_e   = (in_word[15:12] == NIB_E);
		new_item.cls.nib_f   = (in_word[15:12] == NIB_F);
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = mem_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* design/rewf_back.sv */
`default_nettype none

module rewf_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_valid,
	input  rewf_pkg::queue_item_t q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [15:0]           echo_word,
	output logic                  packet_start,
	output logic [1:0]            packet_type,
	output logic                  in_packet,
	output logic                  packet_end,
	output logic [15:0]           packet_length,
	output logic [15:0]           packet_count
);
	import rewf_pkg::*;

	localparam int HIST_N = TRAILER_WINDOW - 1;
	localparam int WIN_BASE = TRAILER_WINDOW - HEADER_WINDOW;

	localparam logic [1:0] PH_SEARCH = 2'd0;
	localparam logic [1:0] PH_FIRST  = 2'd1;
	localparam logic [1:0] PH_SECOND = 2'd2;

	localparam logic [LEN_W-1:0] LEN_MAX   = {LEN_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_START = LEN_W'(HEADER_WINDOW);
	localparam logic [LEN_W-1:0] LEN_HDR   = LEN_W'(FIRST_KIND_HEADER_WORDS);

	// flags of the last eleven words, oldest first
	word_class_t        cls_q [0:HIST_N-1];
	word_class_t        h [0:TRAILER_WINDOW-1];
	logic [1:0]         phase_q;
	logic [LEN_W-1:0]   len_q;
	logic [COUNT_W-1:0] cnt_q;
	logic               out_valid_q;

	logic [WORD_W-1:0]  echo_q;
	logic               start_q;
	logic [TYPE_W-1:0]  type_q;
	logic               inpkt_q;
	logic               end_q;
	logic [LEN_W-1:0]   olen_q;
	logic [COUNT_W-1:0] ocnt_q;

	logic [LEN_W-1:0]   len_inc;
	logic               first_hit;
	logic               second_hit;
	logic               end_first;
	logic               end_second;
	logic               nx_start;
	logic [TYPE_W-1:0]  nx_type;
	logic               nx_inpkt;
	logic               nx_end;
	logic [LEN_W-1:0]   nx_len;
	logic [1:0]         nx_phase;
	logic [LEN_W-1:0]   nx_len_state;
	logic [COUNT_W-1:0] nx_cnt;

	assign q_pop = q_valid && (!out_valid_q || out_ready);

	// history as it stands after this word is pushed
	always_comb begin
		for (int i = 0; i < HIST_N; i++) begin
			h[i] = cls_q[i];
		end
		h[TRAILER_WINDOW-1] = q_item.cls;
	end

	// pattern tests
	always_comb begin
		len_inc = (len_q == LEN_MAX) ? len_q : len_q + LEN_W'(1);
		first_hit = h[WIN_BASE+5].is_8000 && h[WIN_BASE+6].is_0001 &&
			h[WIN_BASE+7].is_8000;
		second_hit = 1'b1;
		for (int i = 0; i < 4; i++) begin
			second_hit = second_hit && h[WIN_BASE+i].nib_9;
		end
		for (int i = 4; i < 7; i++) begin
			second_hit = second_hit && h[WIN_BASE+i].nib_a;
		end
		end_first = (len_inc >= LEN_HDR) && h[0].is_8000 && h[1].is_8000 &&
			h[2].is_ffff && h[3].is_8000;
		end_second = 1'b1;
		for (int i = 4; i < 8; i++) begin
			end_second = end_second && h[i].nib_f;
		end
		for (int i = 8; i < 11; i++) begin
			end_second = end_second && h[i].nib_e;
		end
	end

	// framing decision for the popped word
	always_comb begin
		nx_start     = 1'b0;
		nx_type      = TYPE_NONE;
		nx_inpkt     = 1'b0;
		nx_end       = 1'b0;
		nx_len       = '0;
		nx_phase     = phase_q;
		nx_len_state = len_q;
		nx_cnt       = cnt_q;
		unique case (phase_q) inside
			PH_FIRST, PH_SECOND: begin
				nx_inpkt     = 1'b1;
				nx_type      = (phase_q == PH_FIRST) ? TYPE_FIRST : TYPE_SECOND;
				nx_len       = len_inc;
				nx_len_state = len_inc;
				nx_end       = (phase_q == PH_FIRST) ? end_first : end_second;
				if (nx_end) begin
					nx_phase     = PH_SEARCH;
					nx_len_state = '0;
				end
			end
			default: begin
				if (first_hit || second_hit) begin
					nx_phase     = first_hit ? PH_FIRST : PH_SECOND;
					nx_type      = first_hit ? TYPE_FIRST : TYPE_SECOND;
					nx_len       = LEN_START;
					nx_len_state = LEN_START;
					nx_cnt       = cnt_q + COUNT_W'(1);
					nx_start     = 1'b1;
					nx_inpkt     = 1'b1;
				end else begin
					nx_phase = PH_SEARCH;
				end
			end
		endcase
	end

	// framing state and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			len_q   <= '0;
			cnt_q   <= '0;
			for (int i = 0; i < HIST_N; i++) begin
				cls_q[i] <= '0;
			end
		end else if (q_pop) begin
			phase_q <= nx_phase;
			len_q   <= nx_len_state;
			cnt_q   <= nx_cnt;
			for (int i = 0; i < HIST_N; i++) begin
				cls_q[i] <= nx_end ? '0 : h[i+1];
			end
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			echo_q  <= q_item.word;
			start_q <= nx_start;
			type_q  <= nx_type;
			inpkt_q <= nx_inpkt;
			end_q   <= nx_end;
			olen_q  <= nx_len;
			ocnt_q  <= nx_cnt;
		end
	end

	assign out_valid     = out_valid_q;
	assign echo_word     = echo_q;
	assign packet_start  = start_q;
	assign packet_type   = type_q;
	assign in_packet     = inpkt_q;
	assign packet_end    = end_q;
	assign packet_length = olen_q;
	assign packet_count  = ocnt_q;

endmodule

`default_nettype wire

/* design/raw_event_word_framer_top.sv */
// an accepted word goes through the queue and the output register to m_tdata
// throughput: one word per cycle unless m_tready stalls it, set by the framing update
// a two-word queue between front and back absorbs input words while the output stalls
// reset: arst_n asynchronously clears the queue, the framing state, the match history
// and the output valid; s_tready is high once the queue is cleared
`default_nettype none

module raw_event_word_framer_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // data_word
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // echo_word, packet_length, packet_count
	output logic [3:0]  m_tuser,   // packet_start, packet_type, in_packet
	output logic        m_tlast    // packet_end
);
	import rewf_pkg::*;

	logic        q_valid;
	queue_item_t q_item;
	logic        q_pop;
	logic [15:0] echo_word;
	logic        packet_start;
	logic [1:0]  packet_type;
	logic        in_packet;
	logic        packet_end;
	logic [15:0] packet_length;
	logic [15:0] packet_count;

	// classify and queue
	rewf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_word  (s_tdata),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	// framing state and output register
	rewf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.echo_word     (echo_word),
		.packet_start  (packet_start),
		.packet_type   (packet_type),
		.in_packet     (in_packet),
		.packet_end    (packet_end),
		.packet_length (packet_length),
		.packet_count  (packet_count)
	);

	assign m_tdata = {packet_count, packet_length, echo_word};
	assign m_tuser = {in_packet, packet_type, packet_start};
	assign m_tlast = packet_end;

endmodule

`default_nettype wire
